### src/hsl_pkg.sv
// Package for the hash slot lookup-or-insert core: codes, widths, queue item
// type and the byte-wise CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package hsl_pkg;

   localparam int DEF_TABLE_SLOTS  = 1024;
   localparam int DEF_PROBE_STRIDE = 37;
   localparam int QUEUE_DEPTH      = 2;

   localparam int KEY_W      = 160;
   localparam int KEY_BYTES  = 20;
   localparam int IDX_W      = 10;
   localparam int SIZE_CMP_W = 21;

   // The hash folds two key bytes into the CRC per cycle.
   localparam int HASH_STEPS = KEY_BYTES / 2;
   // A non power of two table reduces the CRC four bits per cycle.
   localparam int MOD_BITS   = 4;
   localparam int MOD_STEPS  = 32 / MOD_BITS;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_FOUND       = 3'd0,
      ST_INSERTED    = 3'd1,
      ST_FULL        = 3'd2,
      ST_READ_USED   = 3'd3,
      ST_READ_UNUSED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_HASH,
      FR_MOD,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ISSUE,
      BK_CHECK
   } back_state_type;

   // Classified item as it travels from the front to the back. The start slot
   // travels next to it, since its width follows the table size.
   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] rd_index;
      logic             rd_in_range;
   } q_item_type;

   // Folds one byte into the reflected CRC; the loop unrolls into an XOR network.
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

### src/hsl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on hsl_pkg for default sizes.
`timescale 1ns / 1ps

module hsl_ram import hsl_pkg::*; #(
   parameter int WIDTH = KEY_W + 1,
   parameter int DEPTH = DEF_TABLE_SLOTS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hsl_queue.sv
// Short register FIFO between the front and the back.
// Depends on hsl_pkg for default sizes.
`timescale 1ns / 1ps

module hsl_queue import hsl_pkg::*; #(
   parameter int WIDTH = $bits(q_item_type),
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/hsl_front.sv
// Front end: accepts items, hashes lookup keys with CRC-32 and reduces the
// hash to a start slot, then hands the item to the queue. Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_front import hsl_pkg::*; #(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_ok,
   input  logic              push,
   output logic              full,
   input  logic              req_opcode,
   input  logic [63:0]       req_key_low,
   input  logic [63:0]       req_key_mid,
   input  logic [31:0]       req_key_high,
   input  logic [IDX_W-1:0]  req_slot_index,
   output logic              q_wr_en,
   output q_item_type        q_item,
   output logic [SLOT_W-1:0] q_slot,
   input  logic              q_full
);

   localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam int HCNT_W  = $clog2(HASH_STEPS);
   localparam int MCNT_W  = $clog2(MOD_STEPS);

   front_state_type   state_ff, state_in;
   q_item_type        item_ff, item_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       crc_ff, crc_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic [31:0]       msh_ff, msh_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;

   logic              take;
   logic [15:0]       pair;
   logic [31:0]       crc_step;
   logic [31:0]       crc_final;
   logic [SLOT_W-1:0] rem_step;
   logic [SLOT_W:0]   trial;
   logic              in_range;

   assign full     = (state_ff != FR_IDLE) || !accept_ok;
   assign take     = push && !full;
   assign in_range = SIZE_CMP_W'(req_slot_index) < SIZE_CMP_W'(TABLE_SLOTS);

   assign pair      = item_ff.key[16*hcnt_ff +: 16];
   assign crc_step  = crc_byte(crc_byte(crc_ff, pair[7:0]), pair[15:8]);
   assign crc_final = ~crc_step;

   // Restoring reduction: shift in one CRC bit at a time, most significant
   // first, and take out the table size whenever the remainder reaches it.
   always_comb begin
      rem_step = rem_ff;
      trial    = '0;
      for (int k = 0; k < MOD_BITS; k++) begin
         trial = {rem_step, msh_ff[31-k]};
         if (trial >= (SLOT_W + 1)'(TABLE_SLOTS)) begin
            trial = trial - (SLOT_W + 1)'(TABLE_SLOTS);
         end
         rem_step = trial[SLOT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (take) begin
               state_in = (op_type'(req_opcode) == OP_READ) ? FR_PUSH : FR_HASH;
            end
         end
         FR_HASH: begin
            if (hcnt_ff == HCNT_W'(HASH_STEPS - 1)) begin
               state_in = IS_POW2 ? FR_PUSH : FR_MOD;
            end
         end
         FR_MOD: begin
            if (mcnt_ff == MCNT_W'(MOD_STEPS - 1)) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!q_full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      item_in = item_ff;
      slot_in = slot_ff;
      crc_in  = crc_ff;
      hcnt_in = hcnt_ff;
      msh_in  = msh_ff;
      rem_in  = rem_ff;
      mcnt_in = mcnt_ff;
      q_wr_en = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (take) begin
               item_in.op          = op_type'(req_opcode);
               item_in.key         = {req_key_high, req_key_mid, req_key_low};
               item_in.rd_index    = req_slot_index;
               item_in.rd_in_range = in_range;
               slot_in             = in_range ? SLOT_W'(req_slot_index) : '0;
               crc_in              = CRC_INIT;
               hcnt_in             = '0;
            end
         end
         FR_HASH: begin
            crc_in  = crc_step;
            hcnt_in = hcnt_ff + 1'b1;
            if (hcnt_ff == HCNT_W'(HASH_STEPS - 1)) begin
               slot_in = crc_final[SLOT_W-1:0];
               msh_in  = crc_final;
               rem_in  = '0;
               mcnt_in = '0;
            end
         end
         FR_MOD: begin
            msh_in  = msh_ff << MOD_BITS;
            rem_in  = rem_step;
            mcnt_in = mcnt_ff + 1'b1;
            slot_in = rem_step;
         end
         FR_PUSH: begin
            q_wr_en = !q_full;
         end
         default: begin
            q_wr_en = 1'b0;
         end
      endcase
   end

   assign q_item = item_ff;
   assign q_slot = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      slot_ff <= slot_in;
      crc_ff  <= crc_in;
      hcnt_ff <= hcnt_in;
      msh_ff  <= msh_in;
      rem_ff  <= rem_in;
      mcnt_ff <= mcnt_in;
   end

endmodule

### src/hsl_back.sv
// Back end: clears the table after reset, then probes the slot RAM for each
// queued item and holds the result in an output register. Depends on hsl_pkg
// and hsl_ram.
`timescale 1ns / 1ps

module hsl_back import hsl_pkg::*; #(
   parameter int TABLE_SLOTS  = DEF_TABLE_SLOTS,
   parameter int PROBE_STRIDE = DEF_PROBE_STRIDE,
   parameter int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   output logic              ready,
   input  logic              q_valid,
   input  q_item_type        q_item,
   input  logic [SLOT_W-1:0] q_slot,
   output logic              q_rd_en,
   output logic              empty,
   input  logic              pop,
   output logic [2:0]        rsp_status,
   output logic [IDX_W-1:0]  rsp_slot_out,
   output logic [63:0]       rsp_stored_low,
   output logic [63:0]       rsp_stored_mid,
   output logic [31:0]       rsp_stored_high
);

   localparam int STEP   = PROBE_STRIDE % TABLE_SLOTS;
   localparam int WORD_W = KEY_W + 1;

   back_state_type    state_ff, state_in;
   q_item_type        item_ff, item_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              out_valid_ff, out_valid_in;
   status_type        status_ff, status_in;
   logic [IDX_W-1:0]  out_slot_ff, out_slot_in;
   logic [KEY_W-1:0]  stored_ff, stored_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [WORD_W-1:0] rd_data;

   logic              take;
   logic              used;
   logic              match;
   logic              last_probe;
   logic              done;
   logic [SLOT_W:0]   sum;
   logic [SLOT_W-1:0] next_slot;

   // Each entry holds the used bit above the key.
   hsl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SLOTS),
      .AW    (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign ready      = (state_ff != BK_CLEAR);
   assign take       = (state_ff == BK_IDLE) && q_valid && (!out_valid_ff || pop);
   assign q_rd_en    = take;
   assign used       = rd_data[KEY_W];
   assign match      = (rd_data[KEY_W-1:0] == item_ff.key);
   assign last_probe = (count_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign sum        = (SLOT_W + 1)'(slot_ff) + (SLOT_W + 1)'(STEP);
   assign next_slot  = (sum >= (SLOT_W + 1)'(TABLE_SLOTS))
                       ? SLOT_W'(sum - (SLOT_W + 1)'(TABLE_SLOTS)) : sum[SLOT_W-1:0];
   // A lookup keeps probing only past a used slot with another key.
   assign done       = (item_ff.op == OP_READ) || !used || match || last_probe;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (take) begin
               state_in = BK_ISSUE;
            end
         end
         BK_ISSUE: state_in = BK_CHECK;
         BK_CHECK: state_in = done ? BK_IDLE : BK_ISSUE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      out_valid_in = out_valid_ff && !pop;
      status_in    = status_ff;
      out_slot_in  = out_slot_ff;
      stored_in    = stored_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = {1'b1, item_ff.key};
      rd_en        = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (take) begin
               item_in  = q_item;
               slot_in  = q_slot;
               count_in = '0;
            end
         end
         BK_ISSUE: begin
            rd_en = 1'b1;
         end
         BK_CHECK: begin
            if (item_ff.op == OP_READ) begin
               out_valid_in = 1'b1;
               out_slot_in  = item_ff.rd_index;
               if (item_ff.rd_in_range && used) begin
                  status_in = ST_READ_USED;
                  stored_in = rd_data[KEY_W-1:0];
               end else begin
                  status_in = ST_READ_UNUSED;
                  stored_in = '0;
               end
            end else if (!used) begin
               wr_en        = 1'b1;
               out_valid_in = 1'b1;
               status_in    = ST_INSERTED;
               out_slot_in  = IDX_W'(slot_ff);
               stored_in    = item_ff.key;
            end else if (match) begin
               out_valid_in = 1'b1;
               status_in    = ST_FOUND;
               out_slot_in  = IDX_W'(slot_ff);
               stored_in    = item_ff.key;
            end else if (last_probe) begin
               out_valid_in = 1'b1;
               status_in    = ST_FULL;
               out_slot_in  = '0;
               stored_in    = '0;
            end else begin
               slot_in  = next_slot;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      slot_ff     <= slot_in;
      count_ff    <= count_in;
      status_ff   <= status_in;
      out_slot_ff <= out_slot_in;
      stored_ff   <= stored_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot_out    = out_slot_ff;
   assign rsp_stored_low  = stored_ff[63:0];
   assign rsp_stored_mid  = stored_ff[127:64];
   assign rsp_stored_high = stored_ff[159:128];

endmodule

### src/hash_slot_lookup_or_insert_core.sv
// Top level of the hash slot lookup-or-insert core: front end, item queue and
// back end. Depends on hsl_pkg, hsl_front, hsl_queue, hsl_back and hsl_ram.
//
//   Channel   Handshake        Payload
//   request   push / full      req_opcode, req_key_low/mid/high, req_slot_index
//   response  pop / empty      rsp_status, rsp_slot_out, rsp_stored_low/mid/high
//
// After reset the back end clears the used bit of every slot, one slot a
// cycle; full stays high until the clear is done.
// A lookup is hashed in the front end two key bytes a cycle (and then reduced
// modulo TABLE_SLOTS when that is not a power of two), then probed in the
// back end, each probe an issue and a check state around the registered RAM read.
// A read item skips the hash and takes one probe. The queue lets the front
// hash the next key while the back probes; a waiting response holds the back.
`timescale 1ns / 1ps

module hash_slot_lookup_or_insert_core import hsl_pkg::*; #(
   parameter int TABLE_SLOTS  = DEF_TABLE_SLOTS,
   parameter int PROBE_STRIDE = DEF_PROBE_STRIDE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_opcode,
   input  logic [63:0]      req_key_low,
   input  logic [63:0]      req_key_mid,
   input  logic [31:0]      req_key_high,
   input  logic [IDX_W-1:0] req_slot_index,
   output logic             empty,
   input  logic             pop,
   output logic [2:0]       rsp_status,
   output logic [IDX_W-1:0] rsp_slot_out,
   output logic [63:0]      rsp_stored_low,
   output logic [63:0]      rsp_stored_mid,
   output logic [31:0]      rsp_stored_high
);

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int ITEM_W = $bits(q_item_type);
   localparam int Q_W    = ITEM_W + SLOT_W;

   logic              back_ready;
   logic              q_wr_en;
   q_item_type        fr_item;
   logic [SLOT_W-1:0] fr_slot;
   logic              q_full;
   logic              q_rd_en;
   logic [Q_W-1:0]    q_rd_data;
   logic              q_valid;

   hsl_front #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .SLOT_W      (SLOT_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept_ok      (back_ready),
      .push           (push),
      .full           (full),
      .req_opcode     (req_opcode),
      .req_key_low    (req_key_low),
      .req_key_mid    (req_key_mid),
      .req_key_high   (req_key_high),
      .req_slot_index (req_slot_index),
      .q_wr_en        (q_wr_en),
      .q_item         (fr_item),
      .q_slot         (fr_slot),
      .q_full         (q_full)
   );

   hsl_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data ({fr_item, fr_slot}),
      .full    (q_full),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .valid   (q_valid)
   );

   hsl_back #(
      .TABLE_SLOTS  (TABLE_SLOTS),
      .PROBE_STRIDE (PROBE_STRIDE),
      .SLOT_W       (SLOT_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ready           (back_ready),
      .q_valid         (q_valid),
      .q_item          (q_item_type'(q_rd_data[Q_W-1:SLOT_W])),
      .q_slot          (q_rd_data[SLOT_W-1:0]),
      .q_rd_en         (q_rd_en),
      .empty           (empty),
      .pop             (pop),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_stored_low  (rsp_stored_low),
      .rsp_stored_mid  (rsp_stored_mid),
      .rsp_stored_high (rsp_stored_high)
   );

endmodule
